[rtl/sspr_pkg.sv]
`timescale 1ns / 1ps

package sspr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    // unused op code, ignored by the receiver
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CSUM    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic       CFG_HEADER_TIMEOUT = 1'b0;
    localparam logic       CFG_BODY_TIMEOUT   = 1'b1;

    localparam logic [15:0] HEADER_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] BODY_TIMEOUT_RST   = 16'd100;

    // index of the length byte, which closes the header
    localparam logic [8:0] LEN_INDEX = 9'd3;
    localparam logic [8:0] SUM_START = 9'd2;
    localparam logic [8:0] BODY_OFS  = 9'd3;

    typedef struct packed {
        logic       byte_valid;
        logic [8:0] byte_index;
        logic [7:0] byte_value;
        logic       packet_done;
        logic [1:0] status;
        logic       busy_res;
    } result_t;

endpackage

[rtl/sspr_engine.sv]
`timescale 1ns / 1ps

module sspr_engine
    import sspr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] header_timeout,
    input  logic [15:0] body_timeout,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] tick_reg, tick_next;

    logic [15:0] tick_inc;
    logic [15:0] limit;
    logic        timed_out;
    logic        last_body;
    logic        len_zero;

    assign tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign limit     = (phase_reg == PH_HEAD) ? header_timeout : body_timeout;
    assign timed_out = (tick_inc >= limit);
    assign last_body = (count_reg >= ({1'b0, len_reg} + BODY_OFS));
    assign len_zero  = (rx_byte == 8'd0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (op)
            OP_ARM:
            begin
                phase_next = PH_HEAD;
            end
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE && timed_out)
                    phase_next = PH_IDLE;
            end
            OP_BYTE:
            begin
                unique case (phase_reg)
                    PH_HEAD:
                    begin
                        if (count_reg >= LEN_INDEX)
                            phase_next = len_zero ? PH_IDLE : PH_BODY;
                    end
                    PH_BODY:
                    begin
                        if (last_body)
                            phase_next = PH_IDLE;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
            default: phase_next = phase_reg;
        endcase
    end

    // datapath and result
    always_comb
    begin
        count_next = count_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        tick_next  = tick_reg;
        res        = '0;
        case (op)
            OP_ARM:
            begin
                count_next = '0;
                len_next   = '0;
                sum_next   = '0;
                tick_next  = '0;
            end
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_next = tick_inc;
                    if (timed_out)
                    begin
                        res.packet_done = 1'b1;
                        res.status      = ST_TIMEOUT;
                    end
                end
            end
            OP_BYTE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res.byte_valid = 1'b1;
                    res.byte_index = count_reg;
                    res.byte_value = rx_byte;
                    tick_next      = '0;
                    count_next     = count_reg + 9'd1;
                    if (phase_reg == PH_HEAD)
                    begin
                        if (count_reg >= SUM_START)
                            sum_next = sum_reg + rx_byte;
                        if (count_reg >= LEN_INDEX)
                        begin
                            len_next = rx_byte;
                            if (len_zero)
                            begin
                                res.packet_done = 1'b1;
                                res.status      = ST_CSUM;
                            end
                        end
                    end
                    else if (last_body)
                    begin
                        res.packet_done = 1'b1;
                        res.status      = (~sum_reg == rx_byte) ? ST_OK : ST_CSUM;
                    end
                    else
                    begin
                        sum_next = sum_reg + rx_byte;
                    end
                end
            end
            default: ;
        endcase
        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            tick_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

[rtl/servo_status_packet_receiver_core.sv]
`timescale 1ns / 1ps

// Servo status packet receiver.
// Input channel (in_valid / in_stall) carries one request per item: op selects
// arm (start a new packet), a received byte in rx_byte, or a timer tick.
// Output channel (out_valid / out_stall) returns exactly one result per request:
// the echoed byte with its packet index, a done flag with status (ok, checksum
// error, timeout) and the busy flag after that request.
// An accepted request lands in the input register; its result is registered
// into the result register as soon as that register is free or being taken
// by the receiver.
// Throughput: one request per cycle unless stalled, set by the single pass from
// the input register through the packet state logic into the result register.
// When the receiver stalls, the result register holds and the input register
// holds its request; in_stall rises only while both are occupied. Reset empties
// both registers, returns the receiver to idle with cleared counters and
// restores the timeouts to 1000 header ticks and 100 body ticks. The user must
// write timeouts via cfg_we / cfg_index / cfg_data only while idle, unenforced.
module servo_status_packet_receiver_core
    import sspr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        byte_valid,
    output logic [8:0]  byte_index,
    output logic [7:0]  byte_value,
    output logic        packet_done,
    output logic [1:0]  status,
    output logic        busy_res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] hdr_to_reg;
    logic [15:0] body_to_reg;

    logic        in_vld_reg;
    logic [1:0]  op_reg;
    logic [7:0]  rx_reg;

    logic        out_vld_reg;
    result_t     res_reg;
    result_t     res_next;

    logic        advance;
    logic        fire;

    // advance the pipe when the result slot is empty or being taken
    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_to_reg  <= HEADER_TIMEOUT_RST;
            body_to_reg <= BODY_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_TIMEOUT: hdr_to_reg  <= cfg_data;
                CFG_BODY_TIMEOUT:   body_to_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register: take a request whenever the slot is free or drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg <= op;
            rx_reg <= rx_byte;
        end
    end

    sspr_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .op             (op_reg),
        .rx_byte        (rx_reg),
        .header_timeout (hdr_to_reg),
        .body_timeout   (body_to_reg),
        .res            (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign out_valid   = out_vld_reg;
    assign byte_valid  = res_reg.byte_valid;
    assign byte_index  = res_reg.byte_index;
    assign byte_value  = res_reg.byte_value;
    assign packet_done = res_reg.packet_done;
    assign status      = res_reg.status;
    assign busy_res    = res_reg.busy_res;

    // a finished packet leaves the receiver idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.packet_done) |-> !res_reg.busy_res)
        else $error("packet done while still busy");

    // status is only reported with a done flag
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !res_reg.packet_done) |-> (res_reg.status == ST_OK))
        else $error("status without packet done");

    // a timeout never comes with a stored byte
    a_timeout_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.status == ST_TIMEOUT) |-> !res_reg.byte_valid)
        else $error("timeout reported on a byte request");

    // input slot stalls only while the result slot is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_vld_reg && in_vld_reg))
        else $error("input stalled with free result slot");

endmodule
